### hw/rtl/b2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants
// Item formats and character codes of the byte-to-decimal transmit queue.
// ----------------------------------------------------------------------------
package b2da_pkg;

  typedef enum logic [0:0] {
    OP_RX      = 1'b0,
    OP_TX_DONE = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
  } evt_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       overflow;
  } tx_item_t;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_SPACE = 8'd32;

endpackage

### hw/rtl/b2da_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_chan_if: valid/ready channel
// Carries one item per handshake; the item type is set per instance.
// ----------------------------------------------------------------------------
interface b2da_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/b2da_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module b2da_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // rd_data holds its value until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/byte_to_decimal_ascii_tx_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_decimal_ascii_tx_queue_unit: decimal text transmit queue
// A received byte is queued as three ASCII digits and a space; characters
// leave one per event through a DEPTH-entry ring in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries events: op = OP_RX with rx_byte queues "hhh " and sends the
//   oldest queued character; op = OP_TX_DONE sends the next queued
//   character, or nothing if the queue is empty.
//   tx carries the sent characters with an overflow flag, set when a
//   received byte lost characters to a full queue.
// Timing:
//   A received byte stores its four characters through the single RAM write
//   port, one character per cycle, and no new item is accepted until they
//   are written. Transmit-complete items can be accepted back to back while
//   tx does not stall. A result is loaded into the stage at the same edge as
//   the RAM read, then into the output register.
// Reset clears pointers, count and all valid flags; RAM contents stay
//   undefined, but only queued entries are ever read.
// When tx stalls, the stage and output register fill and evt.ready drops;
//   no item is lost or duplicated.
// ----------------------------------------------------------------------------
module byte_to_decimal_ascii_tx_queue_unit
  import b2da_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  b2da_chan_if.sink   evt,
  b2da_chan_if.source tx
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic [1:0]    wr_step;
  logic [7:0]    t_chr;
  logic [7:0]    u_chr;
  logic          ovf_acc;

  logic          s1_v;
  logic          s1_fwd;
  logic          s1_rx;
  logic [7:0]    s1_char;

  logic          out_v;
  tx_item_t      out_item;

  logic          step_active;
  logic          out_free;
  logic          s1_go;
  logic          acc;
  logic          acc_rx;
  logic          acc_td;
  logic          has_room;
  logic          we;
  logic          re;
  logic          dec;
  logic [7:0]    wdata;
  logic [7:0]    step_chr;
  logic [7:0]    rd_data;

  // digit split
  logic [7:0]    v;
  logic [1:0]    h;
  logic [6:0]    r;
  logic [14:0]   r_mul;
  logic [3:0]    t;
  logic [6:0]    u;
  logic [7:0]    h_chr;

  always_comb begin
    v = evt.data.rx_byte;
    if (v >= 8'd200) begin
      h = 2'd2;
    end else if (v >= 8'd100) begin
      h = 2'd1;
    end else begin
      h = 2'd0;
    end
    r = 7'(v - 8'd100 * {6'd0, h});
    // r / 10 for r below 100
    r_mul = 15'({8'd0, r} * 15'd205);
    t = r_mul[14:11];
    u = 7'(r - 7'd10 * {3'd0, t});
    h_chr = ASCII_ZERO + {6'd0, h};
  end

  always_comb begin
    case (wr_step)
      2'd3:    step_chr = t_chr;
      2'd2:    step_chr = u_chr;
      default: step_chr = ASCII_SPACE;
    endcase
  end

  assign step_active = (wr_step != 2'd0);
  assign out_free    = !out_v || tx.ready;
  assign s1_go       = s1_v && !step_active && out_free;
  assign evt.ready   = !step_active && (!s1_v || s1_go);
  assign acc         = evt.valid && evt.ready;
  assign acc_rx      = acc && (evt.data.op == OP_RX);
  assign acc_td      = acc && (evt.data.op == OP_TX_DONE) && (count != '0);
  assign has_room    = (count < CW'(DEPTH));

  assign we    = (acc_rx || step_active) && has_room;
  assign wdata = acc_rx ? h_chr : step_chr;
  // with an empty queue the oldest character is the hundreds digit itself
  assign re    = (acc_rx && (count != '0)) || acc_td;
  // a received byte takes its character after the space has been queued
  assign dec   = acc_td || (wr_step == 2'd1);

  assign count_next = count + CW'(we) - CW'(dec);

  b2da_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wptr),
    .wr_data (wdata),
    .rd_en   (re),
    .rd_addr (rptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      rptr    <= '0;
      count   <= '0;
      wr_step <= 2'd0;
      s1_v    <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      count <= count_next;
      if (we) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (acc_rx || acc_td) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end

      if (acc_rx) begin
        wr_step <= 2'd3;
      end else if (step_active) begin
        wr_step <= wr_step - 2'd1;
      end

      if (acc_rx || acc_td) begin
        s1_v <= 1'b1;
      end else if (s1_go) begin
        s1_v <= 1'b0;
      end

      if (s1_go) begin
        out_v <= 1'b1;
      end else if (tx.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_rx) begin
      t_chr   <= ASCII_ZERO + {4'd0, t};
      u_chr   <= ASCII_ZERO + {1'b0, u};
      ovf_acc <= !has_room;
    end else if (step_active && !has_room) begin
      ovf_acc <= 1'b1;
    end
    if (acc_rx || acc_td) begin
      s1_fwd  <= acc_rx && (count == '0);
      s1_rx   <= acc_rx;
      s1_char <= h_chr;
    end
    if (s1_go) begin
      out_item.tx_byte  <= s1_fwd ? s1_char : rd_data;
      out_item.overflow <= s1_rx && ovf_acc;
    end
  end

  assign tx.valid = out_v;
  assign tx.data  = out_item;

  // queue never holds more than DEPTH characters
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("pending count above DEPTH");

  // no new item while the character writes of a received byte are running
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    step_active |-> !evt.ready)
    else $error("input accepted during character writes");

  // a result of a received byte waits in the stage until its writes finish
  a_stage_waits: assert property (@(posedge clk) disable iff (rst)
    (s1_v && step_active) |=> s1_v)
    else $error("result left before queue writes completed");

  // a transmit-complete item never finds the queue empty when it reads
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    acc_td |-> (count != '0))
    else $error("read from empty queue");

endmodule
